FILE: design/spq_pkg.sv
// Package for the stable priority queue: status and operation codes,
// the entry and cell command structs, and the default depth.
// No dependencies; used by every module in the design folder.
`default_nettype none

package spq_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int DATA_W        = 32;
    localparam int PRIO_W        = 8;
    localparam int OCC_W         = 5;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } op_t;

    // One stored entry.
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    // Command broadcast to every cell in the cycle an operation executes.
    typedef struct packed {
        logic              enq;
        logic              deq;
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
    } cmd_t;

endpackage

`default_nettype wire

FILE: design/spq_cell.sv
// One cell of the sorted chain: holds one entry and hands it to a neighbor.
// Depends on spq_pkg for the entry and command structs.
`default_nettype none

module spq_cell
(
    input  wire logic          clk,
    input  wire spq_pkg::cmd_t cmd,
    input  wire logic          valid,
    input  wire logic          left_flag,
    input  wire spq_pkg::entry_t left_entry,
    input  wire spq_pkg::entry_t right_entry,
    output spq_pkg::entry_t    entry,
    output logic               flag
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // The new entry belongs at or before this cell when the cell is empty or
    // holds a strictly lower priority; equal priorities keep arrival order.
    assign flag = !valid || (cmd.prio > entry_reg.prio);

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.enq && flag)
        begin
            if (left_flag)
            begin
                entry_next = left_entry;
            end
            else
            begin
                entry_next.data = cmd.data;
                entry_next.prio = cmd.prio;
            end
        end
        else if (cmd.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

FILE: design/stable_priority_queue.sv
// Top level of the stable priority queue: input holding register, the chain
// of spq_cell instances kept in priority order, and the result register.
// Depends on spq_pkg and spq_cell.
`default_nettype none

//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------------------
//  input   | in_valid  | in_stall  | opcode, data_in, priority_in
//  output  | out_valid | out_stall | status, data_out, priority_out, occupancy
//
// An accepted transfer is held in the input register and then executes over
// the whole cell chain at once, with its result in the result register; a
// new item is not taken while one is held, so the queue cannot accept an item
// before the last one has executed.
// Reset clears the entry count and both valid flags; entry storage is not reset.
// A stalled output only delays execution; one more item can still be accepted
// and waits in the input register until the result register frees up.

module stable_priority_queue
#(
    parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                opcode,
    input  wire logic signed [spq_pkg::DATA_W-1:0]   data_in,
    input  wire logic        [spq_pkg::PRIO_W-1:0]   priority_in,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic             [1:0]                   status,
    output logic signed      [spq_pkg::DATA_W-1:0]   data_out,
    output logic             [spq_pkg::PRIO_W-1:0]   priority_out,
    output logic             [spq_pkg::OCC_W-1:0]    occupancy
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Input holding register.
    logic                       item_valid_reg;
    spq_pkg::op_t               item_op_reg;
    logic [spq_pkg::DATA_W-1:0] item_data_reg;
    logic [spq_pkg::PRIO_W-1:0] item_prio_reg;

    // Entry count and result register.
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic                        out_valid_reg;
    spq_pkg::status_t            status_reg;
    spq_pkg::status_t            status_next;
    logic [spq_pkg::DATA_W-1:0]  data_out_reg;
    logic [spq_pkg::DATA_W-1:0]  data_out_next;
    logic [spq_pkg::PRIO_W-1:0]  prio_out_reg;
    logic [spq_pkg::PRIO_W-1:0]  prio_out_next;
    logic [spq_pkg::OCC_W-1:0]   occ_reg;

    logic            exec;
    logic            is_full;
    logic            is_empty;
    spq_pkg::cmd_t   cmd;

    logic            cell_valid [QUEUE_DEPTH];
    logic            cell_flag  [QUEUE_DEPTH];
    spq_pkg::entry_t cell_entry [QUEUE_DEPTH];

    // The held item executes once the result register is free or being drained.
    assign exec     = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg;
    assign is_full  = (count_reg == CW'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (exec)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_op_reg   <= spq_pkg::op_t'(opcode);
            item_data_reg <= data_in;
            item_prio_reg <= priority_in;
        end
    end

    // The command reaches the cells only in the executing cycle, and a drop on
    // full or a dequeue on empty leaves the chain untouched.
    always_comb
    begin
        cmd.enq  = exec && (item_op_reg == spq_pkg::OP_ENQUEUE) && !is_full;
        cmd.deq  = exec && (item_op_reg == spq_pkg::OP_DEQUEUE) && !is_empty;
        cmd.data = item_data_reg;
        cmd.prio = item_prio_reg;
    end

    // The cells are kept sorted by descending priority, ties in arrival order,
    // so the head cell always holds the entry that a dequeue removes.
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic            left_flag;
            spq_pkg::entry_t left_entry;
            spq_pkg::entry_t right_entry;

            assign cell_valid[gi] = (CW'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign left_flag  = 1'b0;
                assign left_entry = '0;
            end
            else
            begin : g_body
                assign left_flag  = cell_flag[gi-1];
                assign left_entry = cell_entry[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_entry = '0;
            end
            else
            begin : g_inner
                assign right_entry = cell_entry[gi+1];
            end

            spq_cell u_cell
            (
                .clk         (clk),
                .cmd         (cmd),
                .valid       (cell_valid[gi]),
                .left_flag   (left_flag),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .entry       (cell_entry[gi]),
                .flag        (cell_flag[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next    = count_reg;
        status_next   = spq_pkg::ST_ENQUEUED;
        data_out_next = '0;
        prio_out_next = '0;
        case (item_op_reg)
            spq_pkg::OP_ENQUEUE:
            begin
                if (is_full)
                begin
                    status_next = spq_pkg::ST_FULL;
                end
                else
                begin
                    status_next = spq_pkg::ST_ENQUEUED;
                    count_next  = count_reg + CW'(1);
                end
            end
            spq_pkg::OP_DEQUEUE:
            begin
                if (is_empty)
                begin
                    status_next = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    status_next   = spq_pkg::ST_DEQUEUED;
                    data_out_next = cell_entry[0].data;
                    prio_out_next = cell_entry[0].prio;
                    count_next    = count_reg - CW'(1);
                end
            end
            default:
            begin
                status_next = spq_pkg::ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (exec)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            status_reg   <= status_next;
            data_out_reg <= data_out_next;
            prio_out_reg <= prio_out_next;
            occ_reg      <= spq_pkg::OCC_W'(count_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign data_out     = data_out_reg;
    assign priority_out = prio_out_reg;
    assign occupancy    = occ_reg;

endmodule

`default_nettype wire

FILE: design/spq_checker.sv
// Port-level checker for the stable priority queue, bound to the top level.
// Depends on spq_pkg for status codes and field widths.
`default_nettype none

module spq_checker
#(
    parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
)
(
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic                              opcode,
    input wire logic signed [spq_pkg::DATA_W-1:0] data_in,
    input wire logic        [spq_pkg::PRIO_W-1:0] priority_in,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic        [1:0]                 status,
    input wire logic signed [spq_pkg::DATA_W-1:0] data_out,
    input wire logic        [spq_pkg::PRIO_W-1:0] priority_out,
    input wire logic        [spq_pkg::OCC_W-1:0]  occupancy
);

    // A result waiting under stall keeps its whole payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(data_out)
            && $stable(priority_out) && $stable(occupancy))
        else $error("result changed while stalled");

    // Only a dequeue carries data.
    a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != spq_pkg::ST_DEQUEUED) |-> data_out == '0 && priority_out == '0)
        else $error("data on a result that is not a dequeue");

    // An empty report leaves nothing in the queue.
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == spq_pkg::ST_EMPTY) |-> occupancy == '0)
        else $error("empty status with nonzero occupancy");

    // A dropped entry means the queue is at its depth.
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == spq_pkg::ST_FULL)
            |-> occupancy == spq_pkg::OCC_W'(QUEUE_DEPTH))
        else $error("full status below queue depth");

endmodule

bind stable_priority_queue spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (.*);

`default_nettype wire
